// ===== rtl/lpfs_pkg.sv =====
package lpfs_pkg;

  localparam int LED_COUNT_DEF = 8;
  localparam int PWM_BITS_DEF  = 12;
  localparam int COLOR_COUNT   = 3;
  localparam int CMD_W         = 3;
  localparam int LEVEL_IN_W    = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_RGB   = 3'd0,
    CMD_WRITE_COLOR = 3'd1,
    CMD_START       = 3'd2,
    CMD_BLANK       = 3'd3,
    CMD_TICK        = 3'd4
  } cmd_t;

  localparam logic [1:0] COLOR_RED   = 2'd0;
  localparam logic [1:0] COLOR_GREEN = 2'd1;
  localparam logic [1:0] COLOR_BLUE  = 2'd2;

  typedef struct packed {
    logic active;       // frame in progress
    logic fresh;        // current channel not loaded yet
    logic latch_phase;  // all bits sent, latch pending
  } lpfs_status_t;

  typedef struct packed {
    logic serial_data;
    logic shift_clock;
    logic latch_pulse;
    logic output_blanked;
    logic busy_res;
    logic frame_done;
  } lpfs_result_t;

endpackage

// ===== rtl/lpfs_level_bank.sv =====
module lpfs_level_bank #(
  parameter int DEPTH = lpfs_pkg::LED_COUNT_DEF,
  parameter int WIDTH = lpfs_pkg::PWM_BITS_DEF,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [ADDR_W-1:0]        wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [ADDR_W-1:0]        rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;
  logic [WIDTH-1:0] rd_word;
  logic             rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Forward a same-cycle write so the read word is never stale.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else if (wr_en && wr_addr == rd_addr) begin
      rd_ok <= 1'b1;
    end else begin
      rd_ok <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == rd_addr) begin
      rd_word <= wr_data;
    end else begin
      rd_word <= mem[rd_addr];
    end
  end

  // Entries never written read as zero.
  assign rd_data = rd_ok ? rd_word : '0;

endmodule

// ===== rtl/lpfs_shifter.sv =====
module lpfs_shifter #(
  parameter int LED_COUNT = lpfs_pkg::LED_COUNT_DEF,
  parameter int PWM_BITS  = lpfs_pkg::PWM_BITS_DEF,
  localparam int LED_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1,
  localparam int BIT_W    = $clog2(PWM_BITS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  lpfs_pkg::cmd_t         cmd,
  input  logic [PWM_BITS-1:0]    rd_data,
  output lpfs_pkg::lpfs_result_t result,
  output lpfs_pkg::lpfs_status_t status,
  output logic [LED_W-1:0]       led_cnt,
  output logic [1:0]             color_cnt,
  output logic [LED_W-1:0]       led_cnt_next
);

  logic [PWM_BITS-1:0] shift_word, shift_word_next;
  logic [BIT_W-1:0]    bit_cnt, bit_cnt_next;
  logic                active, active_next;
  logic                blank, blank_next;
  logic [1:0]          color_cnt_next;
  logic [PWM_BITS-1:0] word;
  logic                latch;

  always_comb begin
    shift_word_next = shift_word;
    bit_cnt_next    = bit_cnt;
    active_next     = active;
    blank_next      = blank;
    led_cnt_next    = led_cnt;
    color_cnt_next  = color_cnt;
    word            = (bit_cnt == BIT_W'(PWM_BITS)) ? rd_data : shift_word;
    latch           = 1'b0;
    result          = '0;
    if (step) begin
      case (cmd)
        lpfs_pkg::CMD_START: begin
          if (!active) begin
            active_next    = 1'b1;
            led_cnt_next   = LED_W'(LED_COUNT - 1);
            color_cnt_next = lpfs_pkg::COLOR_BLUE;
            bit_cnt_next   = BIT_W'(PWM_BITS);
          end
        end
        lpfs_pkg::CMD_BLANK: begin
          blank_next = 1'b1;
        end
        lpfs_pkg::CMD_TICK: begin
          if (active) begin
            if (bit_cnt == '0) begin
              latch       = 1'b1;
              blank_next  = 1'b0;
              active_next = 1'b0;
            end else begin
              result.serial_data = word[PWM_BITS-1];
              result.shift_clock = 1'b1;
              shift_word_next    = word << 1;
              bit_cnt_next       = bit_cnt - BIT_W'(1);
              // Advance to the next lower channel; channel 0 leaves the latch pending.
              if (bit_cnt_next == '0 &&
                  !(led_cnt == '0 && color_cnt == lpfs_pkg::COLOR_RED)) begin
                bit_cnt_next = BIT_W'(PWM_BITS);
                if (color_cnt == lpfs_pkg::COLOR_RED) begin
                  color_cnt_next = lpfs_pkg::COLOR_BLUE;
                  led_cnt_next   = led_cnt - LED_W'(1);
                end else begin
                  color_cnt_next = color_cnt - 2'd1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    result.latch_pulse    = latch;
    result.frame_done     = latch;
    result.busy_res       = active_next || latch;
    result.output_blanked = blank_next || latch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word <= '0;
      bit_cnt    <= '0;
      active     <= 1'b0;
      blank      <= 1'b0;
      led_cnt    <= '0;
      color_cnt  <= lpfs_pkg::COLOR_RED;
    end else begin
      shift_word <= shift_word_next;
      bit_cnt    <= bit_cnt_next;
      active     <= active_next;
      blank      <= blank_next;
      led_cnt    <= led_cnt_next;
      color_cnt  <= color_cnt_next;
    end
  end

  assign status.active      = active;
  assign status.fresh       = (bit_cnt == BIT_W'(PWM_BITS));
  assign status.latch_phase = active && (bit_cnt == '0);

endmodule

// ===== rtl/led_pwm_frame_serializer_unit.sv =====
// Serial PWM frame driver for LED_COUNT RGB LEDs with PWM_BITS-bit levels. An item is
// taken each cycle while the result register is free or being drained, and its result
// appears in that register on the next cycle. A start command arms a frame; each
// following tick clocks one bit out, MSB first, from the highest channel (last LED, blue)
// down to channel 0, and one more tick latches with blank pulsed. A frame thus spans
// LED_COUNT*3*PWM_BITS + 1 ticks. Levels live in three banks (red, green, blue), each
// with one write and one read port, read every cycle at the LED that comes next, so a
// write lands in time for the following tick. Writes to a channel already loaded in the
// running frame are dropped, as are writes to an LED or color out of range.
module led_pwm_frame_serializer_unit #(
  parameter int LED_COUNT = lpfs_pkg::LED_COUNT_DEF,
  parameter int PWM_BITS  = lpfs_pkg::PWM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  command,
  input  logic [2:0]  led_index,
  input  logic [1:0]  color_index,
  input  logic [11:0] red_level,
  input  logic [11:0] green_level,
  input  logic [11:0] blue_level,
  input  logic [11:0] channel_level,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        serial_data,
  output logic        shift_clock,
  output logic        latch_pulse,
  output logic        output_blanked,
  output logic        busy_res,
  output logic        frame_done
);

  localparam int LED_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  lpfs_pkg::cmd_t         cmd;
  lpfs_pkg::lpfs_result_t res;
  lpfs_pkg::lpfs_status_t status;
  logic                   step;
  logic [LED_W-1:0]       led_cnt, led_cnt_next;
  logic [1:0]             color_cnt;
  logic [LED_W-1:0]       wr_led;
  logic                   led_ok;
  logic [2:0]             can_write;
  logic [2:0]             wr_en;
  logic [PWM_BITS-1:0]    wr_data [3];
  logic [PWM_BITS-1:0]    bank_data [3];
  logic [PWM_BITS-1:0]    rd_data;

  assign cmd        = lpfs_pkg::cmd_t'(command);
  assign item_ready = !result_valid || result_ready;
  assign step       = item_valid && item_ready;
  assign led_ok     = (32'(led_index) < LED_COUNT);
  assign wr_led     = LED_W'(led_index);

  // A channel may be written if it is not yet loaded in the running frame.
  always_comb begin
    for (int c = 0; c < lpfs_pkg::COLOR_COUNT; c++) begin
      if (!status.active) begin
        can_write[c] = 1'b1;
      end else if (status.latch_phase) begin
        can_write[c] = 1'b0;
      end else if (32'(led_index) < 32'(led_cnt)) begin
        can_write[c] = 1'b1;
      end else if (32'(led_index) == 32'(led_cnt)) begin
        can_write[c] = (2'(c) < color_cnt) || (2'(c) == color_cnt && status.fresh);
      end else begin
        can_write[c] = 1'b0;
      end
    end
  end

  always_comb begin
    wr_en = '0;
    wr_data[0] = PWM_BITS'(red_level);
    wr_data[1] = PWM_BITS'(green_level);
    wr_data[2] = PWM_BITS'(blue_level);
    if (step && led_ok) begin
      case (cmd)
        lpfs_pkg::CMD_WRITE_RGB: begin
          wr_en = can_write;
        end
        lpfs_pkg::CMD_WRITE_COLOR: begin
          for (int c = 0; c < lpfs_pkg::COLOR_COUNT; c++) begin
            if (color_index == 2'(c)) begin
              wr_en[c]   = can_write[c];
              wr_data[c] = PWM_BITS'(channel_level);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < lpfs_pkg::COLOR_COUNT; g++) begin : g_bank
    lpfs_level_bank #(
      .DEPTH (LED_COUNT),
      .WIDTH (PWM_BITS)
    ) u_bank (
      .clk     (clk),
      .rst     (rst),
      .wr_en   (wr_en[g]),
      .wr_addr (wr_led),
      .wr_data (wr_data[g]),
      .rd_addr (led_cnt_next),
      .rd_data (bank_data[g])
    );
  end

  always_comb begin
    case (color_cnt)
      lpfs_pkg::COLOR_RED:   rd_data = bank_data[0];
      lpfs_pkg::COLOR_GREEN: rd_data = bank_data[1];
      default:               rd_data = bank_data[2];
    endcase
  end

  lpfs_shifter #(
    .LED_COUNT (LED_COUNT),
    .PWM_BITS  (PWM_BITS)
  ) u_shifter (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .cmd            (cmd),
    .rd_data        (rd_data),
    .result         (res),
    .status         (status),
    .led_cnt        (led_cnt),
    .color_cnt      (color_cnt),
    .led_cnt_next   (led_cnt_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      serial_data    <= res.serial_data;
      shift_clock    <= res.shift_clock;
      latch_pulse    <= res.latch_pulse;
      output_blanked <= res.output_blanked;
      busy_res       <= res.busy_res;
      frame_done     <= res.frame_done;
    end
  end

`ifndef SYNTHESIS
  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("accepted item produced no result");

  a_latch_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && latch_pulse |-> frame_done && output_blanked && busy_res)
    else $error("latch result missing done, blank or busy");

  a_shift_or_latch: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(shift_clock && latch_pulse))
    else $error("shift and latch on the same transfer");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    step && cmd == lpfs_pkg::CMD_TICK && !status.active |=> !shift_clock && !latch_pulse)
    else $error("idle tick shifted or latched");

  a_wr_outside_frame: assert property (@(posedge clk) disable iff (rst)
    status.latch_phase |-> wr_en == '0)
    else $error("level written during latch phase");
`endif

endmodule
